// File: src/vses_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the exp2 root table of the variable-step smoother.
package vses_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int POW_STEPS   = 16;
   localparam int EXP_WIDTH   = 16;
   localparam int EXP_FRAC    = 8;
   localparam int R_FRAC      = 30;
   localparam int R_WIDTH     = R_FRAC + 1;
   localparam int LEAD_W      = $clog2(WEIGHT_BITS + 1);
   localparam int N_W         = LEAD_W + POW_STEPS;
   localparam int Q_W         = N_W + EXP_WIDTH - EXP_FRAC;
   localparam int IP_W        = Q_W - POW_STEPS;
   localparam int SH_W        = IP_W + 1;
   localparam int STEP_W      = $clog2(POW_STEPS);
   localparam int POS_W       = $clog2(WEIGHT_BITS);
   localparam int MUL_A_W     = R_WIDTH + 1;
   localparam int MUL_B_W     = DATA_WIDTH + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W - 1;
   localparam int CSR_INDEX_W = 2;

   localparam logic [EXP_WIDTH-1:0] EXP_ONE = EXP_WIDTH'(1 << EXP_FRAC);

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CEIL_EN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CEIL_VAL = 2'd2;

   localparam logic CMD_APPLY = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG,
      ST_PROD,
      ST_EXP,
      ST_WGT,
      ST_BLEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                          command;
      logic [EXP_WIDTH-1:0]          exponent;
      logic signed [DATA_WIDTH-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  filtered;
      logic                          first_sample;
      logic                          clamped;
   } rsp_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0]        alpha;
      logic                          ceiling_enable;
      logic signed [DATA_WIDTH-1:0]  ceiling_value;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic slot_free;
   } core_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   typedef logic [POW_STEPS-1:0][R_FRAC-1:0] root_tab_type;

   // Integer square root, bit-pair method.
   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      int          i;
      rem   = x;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Entry k holds 0.5^(2^-(k+1)) in Q30: repeated square roots of one half.
   function automatic root_tab_type build_roots();
      root_tab_type tab;
      logic [63:0]  c;
      int           k;
      c = isqrt(64'd1 << (2 * R_FRAC - 1));
      for (k = 0; k < POW_STEPS; k++) begin
         tab[k] = c[R_FRAC-1:0];
         c      = isqrt(c << R_FRAC);
      end
      return tab;
   endfunction

   localparam root_tab_type EXP_ROOT = build_roots();

endpackage

// File: src/vses_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier used by every multiplication of the smoother.
module vses_mul (
   input  logic signed [vses_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [vses_pkg::MUL_B_W-1:0] op_b,
   output logic signed [vses_pkg::PROD_W-1:0]  prod
);

   logic signed [vses_pkg::PROD_W-1:0] a_ext;
   logic signed [vses_pkg::PROD_W-1:0] b_ext;

   assign a_ext = vses_pkg::PROD_W'(op_a);
   assign b_ext = vses_pkg::PROD_W'(op_b);
   assign prod  = a_ext * b_ext;

endmodule

// File: src/vses_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath: log2 squaring, exp2 roots and blend on one multiplier.
module vses_core (
   input  logic                    clock,
   input  logic                    reset,
   input  vses_pkg::core_ctrl_type ctrl,
   input  vses_pkg::req_type       req,
   input  vses_pkg::cfg_type       cfg,
   output vses_pkg::core_stat_type stat,
   output vses_pkg::rsp_type       rsp
);

   vses_pkg::state_type state_ff, state_in;
   logic [vses_pkg::STEP_W-1:0]            step_ff, step_in;
   vses_pkg::req_type                      item_ff, item_in;
   logic [vses_pkg::WEIGHT_BITS-1:0]       m_ff, m_in;
   logic [vses_pkg::POW_STEPS-1:0]         frac_ff, frac_in;
   logic [vses_pkg::Q_W-1:0]               q_ff, q_in;
   logic [vses_pkg::R_WIDTH-1:0]           r_ff, r_in;
   logic [vses_pkg::WEIGHT_BITS-1:0]       w_ff, w_in;
   logic signed [vses_pkg::DATA_WIDTH-1:0] y_ff, y_in;
   logic                                   first_ff, first_in;
   logic                                   clear_ff, clear_in;
   logic signed [vses_pkg::DATA_WIDTH-1:0] smoothed_ff, smoothed_in;
   logic                                   has_value_ff, has_value_in;

   logic signed [vses_pkg::MUL_A_W-1:0]    mul_a;
   logic signed [vses_pkg::MUL_B_W-1:0]    mul_b;
   logic signed [vses_pkg::PROD_W-1:0]     prod;

   logic [vses_pkg::POS_W-1:0]             pos;
   logic [vses_pkg::LEAD_W-1:0]            lead;
   logic [vses_pkg::N_W-1:0]               n_val;
   logic signed [vses_pkg::MUL_B_W-1:0]    diff;
   logic [vses_pkg::WEIGHT_BITS:0]         sq;
   logic [vses_pkg::STEP_W-1:0]            frac_sel;
   logic [vses_pkg::POW_STEPS-1:0]         f_val;
   logic [vses_pkg::IP_W-1:0]              ip;
   logic [vses_pkg::SH_W-1:0]              sh;
   logic [vses_pkg::R_WIDTH-1:0]           shifted;
   logic                                   last_step;
   logic                                   special;
   logic                                   over;

   vses_mul u_mul (
      .op_a (mul_a),
      .op_b (mul_b),
      .prod (prod)
   );

   // Top set bit of alpha.
   always_comb begin
      pos = '0;
      for (int i = 0; i < vses_pkg::WEIGHT_BITS; i++) begin
         if (cfg.alpha[i]) begin
            pos = vses_pkg::POS_W'(i);
         end
      end
   end

   assign lead      = vses_pkg::LEAD_W'(vses_pkg::WEIGHT_BITS) - vses_pkg::LEAD_W'(pos);
   assign n_val     = {lead, {vses_pkg::POW_STEPS{1'b0}}} - vses_pkg::N_W'(frac_ff);
   assign diff      = vses_pkg::MUL_B_W'(smoothed_ff) - vses_pkg::MUL_B_W'(item_ff.sample);
   assign sq        = prod[vses_pkg::WEIGHT_BITS-1 +: vses_pkg::WEIGHT_BITS+1];
   assign frac_sel  = vses_pkg::STEP_W'(vses_pkg::POW_STEPS - 1) - step_ff;
   assign f_val     = q_ff[vses_pkg::POW_STEPS-1:0];
   assign ip        = q_ff[vses_pkg::Q_W-1:vses_pkg::POW_STEPS];
   assign sh        = vses_pkg::SH_W'(ip)
                      + vses_pkg::SH_W'(vses_pkg::R_FRAC - vses_pkg::WEIGHT_BITS);
   assign shifted   = (sh >= vses_pkg::SH_W'(vses_pkg::R_WIDTH)) ? '0 : (r_ff >> sh);
   assign last_step = (step_ff == vses_pkg::STEP_W'(vses_pkg::POW_STEPS - 1));
   assign special   = (req.exponent == vses_pkg::EXP_ONE) || (cfg.alpha == '0);
   assign over      = cfg.ceiling_enable && (y_ff > cfg.ceiling_value);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vses_pkg::ST_IDLE: begin
            if (ctrl.start) begin
               if (req.command == vses_pkg::CMD_CLEAR || !has_value_ff) begin
                  state_in = vses_pkg::ST_DONE;
               end else if (special) begin
                  state_in = vses_pkg::ST_BLEND;
               end else begin
                  state_in = vses_pkg::ST_LOG;
               end
            end
         end
         vses_pkg::ST_LOG: begin
            if (last_step) begin
               state_in = vses_pkg::ST_PROD;
            end
         end
         vses_pkg::ST_PROD:  state_in = vses_pkg::ST_EXP;
         vses_pkg::ST_EXP: begin
            if (last_step) begin
               state_in = vses_pkg::ST_WGT;
            end
         end
         vses_pkg::ST_WGT:   state_in = vses_pkg::ST_BLEND;
         vses_pkg::ST_BLEND: state_in = vses_pkg::ST_DONE;
         vses_pkg::ST_DONE: begin
            if (ctrl.slot_free) begin
               state_in = vses_pkg::ST_IDLE;
            end
         end
         default: state_in = vses_pkg::ST_IDLE;
      endcase
   end

   // Outputs: multiplier operands, status and result.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         vses_pkg::ST_LOG: begin
            mul_a = vses_pkg::MUL_A_W'(m_ff);
            mul_b = vses_pkg::MUL_B_W'(m_ff);
         end
         vses_pkg::ST_PROD: begin
            mul_a = vses_pkg::MUL_A_W'(n_val);
            mul_b = vses_pkg::MUL_B_W'(item_ff.exponent);
         end
         vses_pkg::ST_EXP: begin
            mul_a = vses_pkg::MUL_A_W'(r_ff);
            mul_b = vses_pkg::MUL_B_W'(vses_pkg::EXP_ROOT[step_ff]);
         end
         vses_pkg::ST_BLEND: begin
            mul_a = vses_pkg::MUL_A_W'(w_ff);
            mul_b = diff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      stat.idle = (state_ff == vses_pkg::ST_IDLE);
      stat.done = (state_ff == vses_pkg::ST_DONE) && ctrl.slot_free;

      if (clear_ff) begin
         rsp.filtered     = '0;
         rsp.first_sample = 1'b0;
         rsp.clamped      = 1'b0;
      end else begin
         rsp.filtered     = over ? cfg.ceiling_value : y_ff;
         rsp.first_sample = first_ff;
         rsp.clamped      = over;
      end
   end

   // Datapath register updates.
   always_comb begin
      step_in      = step_ff;
      item_in      = item_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      w_in         = w_ff;
      y_in         = y_ff;
      first_in     = first_ff;
      clear_in     = clear_ff;
      smoothed_in  = smoothed_ff;
      has_value_in = has_value_ff;
      case (state_ff)
         vses_pkg::ST_IDLE: begin
            if (ctrl.start) begin
               item_in  = req;
               step_in  = '0;
               frac_in  = '0;
               m_in     = vses_pkg::WEIGHT_BITS'(cfg.alpha
                          << (vses_pkg::POS_W'(vses_pkg::WEIGHT_BITS - 1) - pos));
               clear_in = (req.command == vses_pkg::CMD_CLEAR);
               first_in = (req.command == vses_pkg::CMD_APPLY) && !has_value_ff;
               y_in     = req.sample;
               // Exponent of one keeps alpha; zero alpha gives zero, or just below one at exponent zero.
               if (req.exponent == vses_pkg::EXP_ONE) begin
                  w_in = cfg.alpha;
               end else if (req.exponent == '0) begin
                  w_in = '1;
               end else begin
                  w_in = '0;
               end
            end
         end
         vses_pkg::ST_LOG: begin
            step_in = step_ff + vses_pkg::STEP_W'(1);
            frac_in = {frac_ff[vses_pkg::POW_STEPS-2:0], sq[vses_pkg::WEIGHT_BITS]};
            m_in    = sq[vses_pkg::WEIGHT_BITS] ? sq[vses_pkg::WEIGHT_BITS:1]
                                                : sq[vses_pkg::WEIGHT_BITS-1:0];
         end
         vses_pkg::ST_PROD: begin
            q_in    = prod[vses_pkg::EXP_FRAC +: vses_pkg::Q_W];
            step_in = '0;
            r_in    = vses_pkg::R_WIDTH'(1) << vses_pkg::R_FRAC;
         end
         vses_pkg::ST_EXP: begin
            step_in = step_ff + vses_pkg::STEP_W'(1);
            if (f_val[frac_sel]) begin
               r_in = prod[vses_pkg::R_FRAC +: vses_pkg::R_WIDTH];
            end
         end
         vses_pkg::ST_WGT: begin
            // Saturate a weight of one to just below one.
            w_in = (|shifted[vses_pkg::R_WIDTH-1:vses_pkg::WEIGHT_BITS]) ? '1
                   : shifted[vses_pkg::WEIGHT_BITS-1:0];
         end
         vses_pkg::ST_BLEND: begin
            y_in = item_ff.sample + vses_pkg::DATA_WIDTH'(prod >>> vses_pkg::WEIGHT_BITS);
         end
         vses_pkg::ST_DONE: begin
            if (ctrl.slot_free) begin
               smoothed_in  = rsp.filtered;
               has_value_in = !clear_ff;
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vses_pkg::ST_IDLE;
         smoothed_ff  <= '0;
         has_value_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         smoothed_ff  <= smoothed_in;
         has_value_ff <= has_value_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      item_ff  <= item_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      w_ff     <= w_in;
      y_ff     <= y_in;
      first_ff <= first_in;
      clear_ff <= clear_in;
   end

endmodule

// File: src/variable_step_exponential_smoother_top.sv
`timescale 1ns / 1ps
// Top level of the variable-step smoother: register bank, sequenced core and result register.
// A general apply item passes from the transfer that brings it in through 16 log2 squarings,
//   1 exponent product, 16 exp2 root steps, weight, blend and finish to the result register.
// Exponent 1.0 or alpha zero go straight to blend and finish; clear or first sample to finish.
// A new item is taken only once the sequencer is back in idle, as all steps share one multiplier.
// Reset (synchronous): alpha all ones, ceiling off at the largest positive value, history empty.
module variable_step_exponential_smoother_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vses_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vses_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vses_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vses_pkg::DATA_WIDTH-1:0]     csr_data
);

   // Configuration registers.
   logic [vses_pkg::WEIGHT_BITS-1:0]       alpha_ff, alpha_in;
   logic                                   ceil_en_ff, ceil_en_in;
   logic signed [vses_pkg::DATA_WIDTH-1:0] ceil_val_ff, ceil_val_in;

   // Result register: lets the core take and work on the next item while a result still waits downstream.
   logic                                   rsp_valid_ff, rsp_valid_in;
   vses_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   vses_pkg::cfg_type                      cfg;
   vses_pkg::core_ctrl_type                core_ctrl;
   vses_pkg::core_stat_type                core_stat;
   vses_pkg::rsp_type                      core_rsp;
   logic                                   csr_write;

   // Writes are always taken: csr_ready is tied high.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      alpha_in    = alpha_ff;
      ceil_en_in  = ceil_en_ff;
      ceil_val_in = ceil_val_ff;
      if (csr_write) begin
         case (csr_index)
            vses_pkg::CSR_ALPHA:    alpha_in    = csr_data[vses_pkg::WEIGHT_BITS-1:0];
            vses_pkg::CSR_CEIL_EN:  ceil_en_in  = csr_data[0];
            vses_pkg::CSR_CEIL_VAL: ceil_val_in = csr_data;
            default:                alpha_in    = alpha_ff;
         endcase
      end
   end

   assign cfg.alpha          = alpha_ff;
   assign cfg.ceiling_enable = ceil_en_ff;
   assign cfg.ceiling_value  = ceil_val_ff;

   // Take a new item only while the sequencer sits idle.
   assign req_ready           = core_stat.idle;
   assign core_ctrl.start     = req_valid && req_ready;
   // The core may hand over its result when the output register is empty or draining.
   assign core_ctrl.slot_free = !rsp_valid_ff || rsp_ready;

   vses_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (core_ctrl),
      .req   (req_data),
      .cfg   (cfg),
      .stat  (core_stat),
      .rsp   (core_rsp)
   );

   // Load on core completion, drop after the downstream transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= '1;
         ceil_en_ff   <= 1'b0;
         ceil_val_ff  <= {1'b0, {(vses_pkg::DATA_WIDTH - 1){1'b1}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         ceil_en_ff   <= ceil_en_in;
         ceil_val_ff  <= ceil_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // The core never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // An accepted item always takes the sequencer out of idle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      core_ctrl.start |=> !core_stat.idle)
      else $error("sequencer stayed idle after accepting an item");

   // A clamped result carries exactly the ceiling, and only with clamping enabled.
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.clamped) |->
         (ceil_en_ff && rsp_data_ff.filtered == ceil_val_ff))
      else $error("clamped result differs from the ceiling");

   // A stalled result holds valid and payload until the downstream transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result changed while stalled");
`endif

endmodule
